>>> hw/rtl/mbmn_pkg.sv
package mbmn_pkg;

    // Operation carried by each input item.
    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    localparam int MEL_W = 8;
    typedef logic signed [MEL_W-1:0] mel_t;

    // Largest magnitude of one mel value.
    localparam int MEL_MAG = 128;

    // The mean lies in -128..127.
    localparam int MEAN_W = MEL_W + 1;

    // Width in which the working value (value - mean) * 2 - offset is computed.
    localparam int NORM_W = MEL_W + 2;

    // Scale and offset of the normalized output.
    localparam int NORM_SHIFT  = 1;
    localparam int NORM_OFFSET = 99;

    // A bin sum holds n_vectors values of magnitude up to MEL_MAG without wrapping.
    function automatic int sum_width(input int n_vectors);
        return $clog2(n_vectors * MEL_MAG) + 1;
    endfunction

endpackage

>>> hw/rtl/mbmn_in_if.sv
interface mbmn_in_if;
    logic               valid;
    logic               ready;
    mbmn_pkg::op_t      op;
    mbmn_pkg::mel_t     mel_value;

    modport source
    (
        output valid,
        output op,
        output mel_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  op,
        input  mel_value,
        output ready
    );
endinterface

>>> hw/rtl/mbmn_out_if.sv
interface mbmn_out_if;
    logic               valid;
    logic               ready;
    mbmn_pkg::mel_t     normalized;
    logic               frame_end;

    modport source
    (
        output valid,
        output normalized,
        output frame_end,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  normalized,
        input  frame_end,
        output ready
    );
endinterface

>>> hw/rtl/mbmn_mean_div.sv
module mbmn_mean_div #(
    parameter int N_VECTORS = 10
) (
    input  logic                                                clk,
    input  logic                                                en,
    input  logic signed [mbmn_pkg::sum_width(N_VECTORS)-1:0]    sum,
    output logic signed [mbmn_pkg::MEAN_W-1:0]                  mean
);

    localparam int SUM_W   = mbmn_pkg::sum_width(N_VECTORS);
    localparam int SHIFT   = SUM_W + $clog2(N_VECTORS);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int Q_W     = mbmn_pkg::MEAN_W - 1;
    // Rounded-up reciprocal; with this shift the quotient is exact for every
    // magnitude a bin sum can reach.
    localparam longint RECIP = ((64'd1 <<< SHIFT) + N_VECTORS - 1) / N_VECTORS;

    logic [SUM_W-1:0]                   mag_next;
    logic [SUM_W-1:0]                   mag_reg;
    logic                               neg_reg;
    logic [PROD_W-1:0]                  prod;
    logic signed [mbmn_pkg::MEAN_W-1:0] quot;
    logic signed [mbmn_pkg::MEAN_W-1:0] mean_next;
    logic signed [mbmn_pkg::MEAN_W-1:0] mean_reg;

    assign mag_next = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= sum[SUM_W-1];
        end
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign prod      = PROD_W'(mag_reg) * PROD_W'(RECIP_W'(RECIP));
    assign quot      = {1'b0, prod[SHIFT +: Q_W]};
    assign mean_next = neg_reg ? -quot : quot;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

>>> hw/rtl/melspec_band_mean_normalizer_unit.sv
// Loads one frame of N_VECTORS x N_BINS signed mel values (op = load) and
// then returns one normalized value per fetch (op = fetch), in load order:
// ((value - bin mean) * 2 - 99) wrapped to 8 bits, the mean truncated toward
// zero. frame_end marks the last value of the frame, after which the block
// loads a new frame with its bin sums cleared. Fetches during loading and loads
// during draining are taken and dropped without a result. One item is accepted
// every cycle while the result side takes its items; a fetch's result is
// presented after the registered bin-sum read, the two-stage constant divider
// and the result register. No clearing pass is needed after reset.
module melspec_band_mean_normalizer_unit #(
    parameter int N_VECTORS = 10,
    parameter int N_BINS    = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    mbmn_in_if.sink         in,
    mbmn_out_if.source      out
);

    localparam int FRAME_LEN = N_VECTORS * N_BINS;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int BIN_W     = (N_BINS > 1) ? $clog2(N_BINS) : 1;
    localparam int SUM_W     = mbmn_pkg::sum_width(N_VECTORS);
    localparam int NORM_W    = mbmn_pkg::NORM_W;

    // Front-end control.
    logic               advance;
    logic               accept;
    logic               take_load;
    logic               take_fetch;
    logic               at_last;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [BIN_W-1:0]   bin_reg;
    logic [BIN_W-1:0]   bin_next;
    logic               draining_reg;
    logic               draining_next;
    logic               clear_sums;

    // Stores.
    mbmn_pkg::mel_t             fs_mem [FRAME_LEN];
    logic signed [SUM_W-1:0]    sum_mem [N_BINS];
    logic [N_BINS-1:0]          sum_vld_reg;

    // Stage 1: store read data and the item.
    logic                       s1_vld_reg;
    logic                       s1_load_reg;
    logic                       s1_last_reg;
    logic [BIN_W-1:0]           s1_bin_reg;
    mbmn_pkg::mel_t             s1_val_reg;
    mbmn_pkg::mel_t             fs_rd_reg;
    logic signed [SUM_W-1:0]    sum_rd_reg;
    logic                       sv_bit_reg;
    logic                       hit_reg;
    logic signed [SUM_W-1:0]    byp_reg;
    logic signed [SUM_W-1:0]    sum_cur;
    logic signed [SUM_W-1:0]    sum_new;
    logic                       s1_write;

    // Stages 2 and 3 run alongside the divider.
    logic                       s2_vld_reg;
    logic                       s2_last_reg;
    mbmn_pkg::mel_t             s2_val_reg;
    logic                       s3_vld_reg;
    logic                       s3_last_reg;
    mbmn_pkg::mel_t             s3_val_reg;
    logic signed [mbmn_pkg::MEAN_W-1:0] mean;

    // Result register.
    logic                       out_vld_reg;
    logic                       out_vld_next;
    mbmn_pkg::mel_t             normalized_reg;
    mbmn_pkg::mel_t             normalized_next;
    logic                       frame_end_reg;
    logic signed [NORM_W-1:0]   diff;
    logic signed [NORM_W-1:0]   norm_full;

    assign advance    = !out_vld_reg || out.ready;
    assign in.ready   = advance;
    assign accept     = in.valid && advance;
    assign take_load  = accept && (in.op == mbmn_pkg::OP_LOAD) && !draining_reg;
    assign take_fetch = accept && (in.op == mbmn_pkg::OP_FETCH) && draining_reg;
    assign at_last    = (idx_reg == IDX_W'(FRAME_LEN - 1));

    always_comb
    begin
        idx_next      = idx_reg;
        bin_next      = bin_reg;
        draining_next = draining_reg;
        clear_sums    = 1'b0;
        if (take_load || take_fetch)
        begin
            idx_next = at_last ? '0 : idx_reg + 1'b1;
            bin_next = (bin_reg == BIN_W'(N_BINS - 1)) ? '0 : bin_reg + 1'b1;
            if (at_last)
            begin
                draining_next = take_load;
                clear_sums    = take_fetch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            bin_reg      <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            bin_reg      <= bin_next;
            draining_reg <= draining_next;
        end
    end

    // Frame store: written by loads, read by fetches at the same index counter.
    always_ff @(posedge clk)
    begin
        if (take_load)
        begin
            fs_mem[idx_reg] <= in.mel_value;
        end
        if (advance)
        begin
            fs_rd_reg <= fs_mem[idx_reg];
        end
    end

    // A sum whose valid bit is clear reads as zero. A write landing on the same
    // edge as the read is caught by the bypass.
    assign sum_cur  = hit_reg ? byp_reg : (sv_bit_reg ? sum_rd_reg : '0);
    assign sum_new  = sum_cur + SUM_W'(s1_val_reg);
    assign s1_write = advance && s1_vld_reg && s1_load_reg;

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            sum_mem[s1_bin_reg] <= sum_new;
        end
        if (advance)
        begin
            sum_rd_reg <= sum_mem[bin_reg];
            sv_bit_reg <= sum_vld_reg[bin_reg];
            hit_reg    <= s1_vld_reg && s1_load_reg && (s1_bin_reg == bin_reg);
            byp_reg    <= sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= '0;
        end
        else if (clear_sums)
        begin
            sum_vld_reg <= '0;
        end
        else if (s1_write)
        begin
            sum_vld_reg[s1_bin_reg] <= 1'b1;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg  <= take_load || take_fetch;
            s2_vld_reg  <= s1_vld_reg && !s1_load_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    assign out_vld_next = s3_vld_reg;

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_load_reg    <= take_load;
            s1_last_reg    <= at_last;
            s1_bin_reg     <= bin_reg;
            s1_val_reg     <= in.mel_value;
            s2_last_reg    <= s1_last_reg;
            s2_val_reg     <= fs_rd_reg;
            s3_last_reg    <= s2_last_reg;
            s3_val_reg     <= s2_val_reg;
            normalized_reg <= normalized_next;
            frame_end_reg  <= s3_last_reg;
        end
    end

    mbmn_mean_div #(
        .N_VECTORS (N_VECTORS)
    ) u_mean_div (
        .clk  (clk),
        .en   (advance),
        .sum  (sum_cur),
        .mean (mean)
    );

    // Only the low bits are kept, so the working width just has to cover them.
    assign diff            = NORM_W'(s3_val_reg) - NORM_W'(mean);
    assign norm_full       = (diff <<< mbmn_pkg::NORM_SHIFT)
                             - NORM_W'(mbmn_pkg::NORM_OFFSET);
    assign normalized_next = norm_full[mbmn_pkg::MEL_W-1:0];

    assign out.valid      = out_vld_reg;
    assign out.normalized = normalized_reg;
    assign out.frame_end  = frame_end_reg;

endmodule
